[hdl/ta_pkg.sv]
package ta_pkg;

    // Widths fixed by the field definitions
    localparam int SAMPLE_W = 10;
    localparam int DEG_W    = 9;
    localparam int SP_W     = 7;
    localparam int BAND_W   = 6;
    localparam int STEP_W   = 5;
    localparam int DIGIT_W  = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Full-scale degrees for a converter reading of 1023
    localparam int DEG_MAX  = 500;
    localparam int ADC_FULL = 1023;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_UP     = 2'd1,
        CMD_DOWN   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_BAND      = 3'd0,
        REG_SET_MIN   = 3'd1,
        REG_SET_MAX   = 3'd2,
        REG_SET_START = 3'd3,
        REG_SET_STEP  = 3'd4
    } t_reg_idx;

    localparam logic [BAND_W-1:0] BAND_RST      = BAND_W'(5);
    localparam logic [SP_W-1:0]   SET_MIN_RST   = SP_W'(35);
    localparam logic [SP_W-1:0]   SET_MAX_RST   = SP_W'(75);
    localparam logic [SP_W-1:0]   SET_START_RST = SP_W'(60);
    localparam logic [STEP_W-1:0] SET_STEP_RST  = STEP_W'(5);

    typedef struct packed {
        t_cmd                cmd;
        logic [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic               heater_on;
        logic               fan_on;
        logic [DIGIT_W-1:0] set_tens;
        logic [DIGIT_W-1:0] set_units;
        logic [DEG_W-1:0]   average_temp;
        logic               average_valid;
    } t_out_res;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [SP_W-1:0]   set_min;
        logic [SP_W-1:0]   set_max;
        logic [SP_W-1:0]   set_start;
        logic [STEP_W-1:0] set_step;
    } t_cfg;

    // Staged request between the front end and the control stage
    typedef struct packed {
        logic             vld;
        t_cmd             cmd;
        logic [DEG_W-1:0] deg;
    } t_stage;

endpackage

[hdl/ta_regs.sv]
module ta_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ta_pkg::ADDR_W-1:0] paddr,
    input  logic [ta_pkg::DATA_W-1:0] pwdata,
    output logic [ta_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output ta_pkg::t_cfg              o_cfg
);
    import ta_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_BAND:      n_cfg.band      = pwdata[BAND_W-1:0];
                REG_SET_MIN:   n_cfg.set_min   = pwdata[SP_W-1:0];
                REG_SET_MAX:   n_cfg.set_max   = pwdata[SP_W-1:0];
                REG_SET_START: n_cfg.set_start = pwdata[SP_W-1:0];
                REG_SET_STEP:  n_cfg.set_step  = pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BAND:      prdata = DATA_W'(r_cfg.band);
            REG_SET_MIN:   prdata = DATA_W'(r_cfg.set_min);
            REG_SET_MAX:   prdata = DATA_W'(r_cfg.set_max);
            REG_SET_START: prdata = DATA_W'(r_cfg.set_start);
            REG_SET_STEP:  prdata = DATA_W'(r_cfg.set_step);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band      <= BAND_RST;
            r_cfg.set_min   <= SET_MIN_RST;
            r_cfg.set_max   <= SET_MAX_RST;
            r_cfg.set_start <= SET_START_RST;
            r_cfg.set_step  <= SET_STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/ta_front.sv]
module ta_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ta_pkg::t_in_req i_in_data,
    input  logic            i_take,
    output ta_pkg::t_stage  o_stage
);
    import ta_pkg::*;

    localparam int PROD_W = 19;

    logic [PROD_W-1:0] w_prod;
    logic [DEG_W-1:0]  w_q0;
    logic [10:0]       w_rem;
    logic [DEG_W-1:0]  w_deg;

    logic             r_vld;
    logic             n_vld;
    t_cmd             r_cmd;
    logic [DEG_W-1:0] r_deg;

    // sample*500/1023: x = 1024*q0 + lo = 1023*q0 + (q0 + lo), remainder stays below 2*1023
    assign w_prod = PROD_W'(i_in_data.sample) * PROD_W'(DEG_MAX);
    assign w_q0   = w_prod[PROD_W-1:10];
    assign w_rem  = 11'(w_prod[9:0]) + 11'(w_q0);
    assign w_deg  = (w_rem >= 11'(ADC_FULL)) ? w_q0 + DEG_W'(1) : w_q0;

    assign o_in_ready = !r_vld || i_take;

    always_comb begin
        n_vld = r_vld;
        if (i_in_valid && o_in_ready) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_in_data.cmd;
            r_deg <= w_deg;
        end
    end

    assign o_stage.vld = r_vld;
    assign o_stage.cmd = r_cmd;
    assign o_stage.deg = r_deg;

endmodule

[hdl/ta_ctrl.sv]
module ta_ctrl #(
    parameter int WINDOW = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ta_pkg::t_stage   i_stage,
    input  ta_pkg::t_cfg     i_cfg,
    output logic             o_take,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ta_pkg::t_out_res o_out_data
);
    import ta_pkg::*;

    localparam int CNT_W   = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(WINDOW * DEG_MAX + 1);
    // Reciprocal error times sum stays below 2**SHIFT, so the quotient is exact
    localparam int SHIFT   = SUM_W + 7;
    localparam int unsigned RECIP = (32'd1 << SHIFT) / WINDOW + 1;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

    logic [SP_W-1:0]  r_setpoint, n_setpoint;
    logic             r_started, n_started;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [DEG_W-1:0] r_avg, n_avg;
    logic             r_heat, n_heat;
    logic             r_fan, n_fan;
    logic             r_out_vld, n_out_vld;
    t_out_res         r_out, n_out;

    logic [SUM_W-1:0]  w_sum_add;
    logic [PROD_W-1:0] w_prod;
    logic [DEG_W-1:0]  w_avg;
    logic [SP_W-1:0]   w_sp_base;
    logic [SP_W:0]     w_sp_up;
    logic [SP_W:0]     w_min_step;
    logic [SP_W-1:0]   w_sp_upd;
    logic [SP_W-1:0]   w_sp_dnd;
    logic [9:0]        w_hi;
    logic [9:0]        w_lo;
    logic [14:0]       w_tens_p;
    logic [DIGIT_W-1:0] w_tens;
    logic [SP_W-1:0]   w_units;
    logic              w_hit;

    assign o_take = i_stage.vld && (!r_out_vld || i_out_ready);

    // Sample path: accumulate and divide by the window through a reciprocal
    assign w_sum_add = r_sum + SUM_W'(i_stage.deg);
    assign w_prod    = PROD_W'(w_sum_add) * PROD_W'(RECIP);
    assign w_avg     = w_prod[SHIFT +: DEG_W];

    // Band compare against the present setpoint, widened so nothing wraps
    assign w_hi = 10'(r_setpoint) + 10'(i_cfg.band);
    assign w_lo = 10'(w_avg) + 10'(i_cfg.band);

    // Button path: the first press steps from the start value
    assign w_sp_base  = r_started ? r_setpoint : i_cfg.set_start;
    assign w_sp_up    = (SP_W+1)'(w_sp_base) + (SP_W+1)'(i_cfg.set_step);
    assign w_min_step = (SP_W+1)'(i_cfg.set_min) + (SP_W+1)'(i_cfg.set_step);

    always_comb begin
        w_sp_upd = w_sp_base;
        if (w_sp_base < i_cfg.set_max) begin
            w_sp_upd = (w_sp_up > (SP_W+1)'(i_cfg.set_max)) ? i_cfg.set_max
                                                            : w_sp_up[SP_W-1:0];
        end
        w_sp_dnd = w_sp_base;
        if (w_sp_base > i_cfg.set_min) begin
            w_sp_dnd = ((SP_W+1)'(w_sp_base) >= w_min_step)
                     ? w_sp_base - SP_W'(i_cfg.set_step) : i_cfg.set_min;
        end
    end

    always_comb begin
        n_setpoint = r_setpoint;
        n_started  = r_started;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_avg      = r_avg;
        n_heat     = r_heat;
        n_fan      = r_fan;
        w_hit      = 1'b0;
        if (o_take) begin
            case (i_stage.cmd)
                CMD_SAMPLE: begin
                    if (r_cnt == CNT_LAST) begin
                        w_hit = 1'b1;
                        n_sum = '0;
                        n_cnt = '0;
                        n_avg = w_avg;
                        if (10'(w_avg) > w_hi) begin
                            n_fan  = 1'b1;
                            n_heat = 1'b0;
                        end else if (w_lo < 10'(r_setpoint)) begin
                            n_heat = 1'b1;
                            n_fan  = 1'b0;
                        end
                    end else begin
                        n_sum = w_sum_add;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                CMD_UP: begin
                    n_started  = 1'b1;
                    n_setpoint = w_sp_upd;
                end
                CMD_DOWN: begin
                    n_started  = 1'b1;
                    n_setpoint = w_sp_dnd;
                end
                default: ;
            endcase
        end
    end

    // Decimal digits: (s*205)>>11 is exact for seven-bit values
    assign w_tens_p = 15'(n_setpoint) * 15'd205;
    assign w_tens   = w_tens_p[14:11];
    assign w_units  = n_setpoint - SP_W'(w_tens) * SP_W'(10);

    always_comb begin
        n_out.heater_on     = n_heat;
        n_out.fan_on        = n_fan;
        n_out.set_tens      = w_tens;
        n_out.set_units     = w_units[DIGIT_W-1:0];
        n_out.average_temp  = n_avg;
        n_out.average_valid = w_hit;
        if (o_take) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_started  <= 1'b0;
            r_cnt      <= '0;
            r_sum      <= '0;
            r_avg      <= '0;
            r_heat     <= 1'b0;
            r_fan      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_setpoint <= n_setpoint;
            r_started  <= n_started;
            r_cnt      <= n_cnt;
            r_sum      <= n_sum;
            r_avg      <= n_avg;
            r_heat     <= n_heat;
            r_fan      <= n_fan;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[hdl/thermostat_average_hysteresis_core.sv]
// Thermostat with block averaging and a hysteresis band. Each request is a
// sensor sample or an up or down button press, and each gives exactly one
// result. A sample is scaled to degrees (reading*500/1023, truncated) and
// summed; every WINDOW-th sample forms the block average, which drives the
// heater and fan outside setpoint +/- band and holds them inside it. A
// button press steps the setpoint by set_step within set_min..set_max, the
// first press starting from set_start. Throughput is one request per cycle
// while results are not stalled; the degree scaling happens in the
// input register, and the rest in the result register (where the sum, the
// reciprocal divide by WINDOW, the band compare and the setpoint step all
// resolve in a single pass). Registers sit on the APB port at byte offsets
// 0 band, 4 set_min, 8 set_max, 12 set_start, 16 set_step, and are to be
// written only while the block is idle. WINDOW ranges from 2 to 64.
module thermostat_average_hysteresis_core #(
    parameter int WINDOW = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  ta_pkg::t_in_req           i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output ta_pkg::t_out_res          o_out_data,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ta_pkg::ADDR_W-1:0] paddr,
    input  logic [ta_pkg::DATA_W-1:0] pwdata,
    output logic [ta_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import ta_pkg::*;

    t_cfg   w_cfg;
    t_stage w_stage;
    logic   w_take;

    // Hold the configuration registers and serve APB reads
    ta_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Register the request and scale the reading to degrees on the way in;
    // a new request is taken when the stage is empty or its request advances
    ta_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_take     (w_take),
        .o_stage    (w_stage)
    );

    // Advance the thermostat state and load the result register; the staged
    // request moves on whenever the result register is empty or being drained
    ta_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .i_cfg       (w_cfg),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[hdl/ta_chk.sv]
module ta_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input ta_pkg::t_out_res o_out_data
);
    import ta_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.heater_on && o_out_data.fan_on))
        else $error("heater and fan both on");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.average_temp <= DEG_W'(DEG_MAX)
                        && o_out_data.set_units <= DIGIT_W'(9))
        else $error("average or units digit out of range");

endmodule

bind thermostat_average_hysteresis_core ta_chk u_ta_chk (.*);
